// ----- src/psg_square_noise_envelope_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sound generator
// Concurrent checks that are sampled on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PSG_SQUARE_NOISE_ENVELOPE_ASSERT_SVH
`define PSG_SQUARE_NOISE_ENVELOPE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/psg_pkg.sv -----
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, register numbers and the volume table of the sound generator.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2
    } psg_op_t;

    localparam int NUM_REGS  = 16;
    localparam int NUM_CHANS = 3;

    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_LEVEL_A   = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam logic [5:0] VOL_TABLE [16] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd7, 6'd10,
        6'd13, 6'd18, 6'd24, 6'd30, 6'd36, 6'd40, 6'd42, 6'd42
    };

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] idx;
        logic [7:0] data;
    } psg_cmd_t;

    typedef struct packed {
        logic [7:0]                 mixer;
        logic [NUM_CHANS-1:0][7:0]  level;
        logic [NUM_CHANS-1:0]       tone;
        logic                       noise;
        logic [3:0]                 env_volume;
    } psg_mix_view_t;

endpackage

`default_nettype wire

// ----- src/psg_cmd_if.sv -----
// ----------------------------------------------------------------------------
// psg_cmd_if
// Command channel: one word carries an operation, a register number and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [3:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input opcode, input reg_index, input write_data,
                  output ready);
endinterface

`default_nettype wire

// ----- src/psg_res_if.sv -----
// ----------------------------------------------------------------------------
// psg_res_if
// Result channel: one word carries the mixed amplitude and the read data.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] amplitude;
    logic [7:0] read_data;

    modport source (output valid, output amplitude, output read_data, input ready);
    modport sink (input valid, input amplitude, input read_data, output ready);
endinterface

`default_nettype wire

// ----- src/psg_square_noise_envelope.sv -----
// ----------------------------------------------------------------------------
// psg_square_noise_envelope
// Three-channel square-wave sound generator with noise and envelope, driven by
// register write, register read and tick words; each word yields one result.
//
//   Channel  Direction  Payload
//   cmd      in         opcode[1:0], reg_index[3:0], write_data[7:0]
//   res      out        amplitude[6:0], read_data[7:0]
//
// One command word is taken every cycle unless res stalls; it waits in cmd_reg
// and its result is registered; a one-step state update sets the one-word rate.
// Reset clears the registers, counters, envelope and both pipeline stages.
// A stall on res holds the result and, if the staged word cannot move, cmd.
// ----------------------------------------------------------------------------
`default_nettype none
`include "psg_square_noise_envelope_assert.svh"

module psg_square_noise_envelope (
    input  wire logic clk,
    input  wire logic rst_n,
    psg_cmd_if.sink   cmd,
    psg_res_if.source res
);
    import psg_pkg::*;

    logic                in_valid_reg;
    psg_cmd_t            cmd_reg;
    logic                out_valid_reg;
    logic [6:0]          amp_reg;
    logic [7:0]          rdata_reg;
    logic                advance;
    psg_mix_view_t       view;
    logic [6:0]          amp_next;
    logic [7:0]          rdata_next;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;

    psg_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .cmd       (cmd_reg),
        .view      (view),
        .read_data (rdata_next)
    );

    psg_mix u_mix (
        .view      (view),
        .amplitude (amp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= '{op: cmd.opcode, idx: cmd.reg_index, data: cmd.write_data};
        end
        if (advance)
        begin
            amp_reg   <= amp_next;
            rdata_reg <= rdata_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.amplitude = amp_reg;
    assign res.read_data = rdata_reg;

    `PSG_ASSERT_NEXT(a_read_data_zero, advance && (psg_op_t'(cmd_reg.op) != OP_READ), res.read_data == 8'd0, "read data is nonzero after a word that is not a read")
    `PSG_ASSERT_NEXT(a_staged_word_kept, in_valid_reg && !advance, in_valid_reg && $stable(cmd_reg), "staged command word was lost or changed")
    `PSG_ASSERT_NEXT(a_result_loaded, advance, res.valid && (res.amplitude <= 7'd126), "processed word did not produce a valid result")

endmodule

`default_nettype wire

// ----- src/psg_mix.sv -----
// ----------------------------------------------------------------------------
// psg_mix
// Gates each channel by tone and noise, looks up its volume and sums the three.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_mix (
    input  wire psg_pkg::psg_mix_view_t view,
    output logic [6:0]                  amplitude
);
    import psg_pkg::*;

    always_comb
    begin
        logic [6:0] sum;
        logic [3:0] lvl;
        logic       audible;
        sum = 7'd0;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            audible = (view.mixer[c] | view.tone[c]) & (view.mixer[c + 3] | view.noise);
            lvl = view.level[c][4] ? view.env_volume : view.level[c][3:0];
            if (audible)
            begin
                sum = sum + {1'b0, VOL_TABLE[lvl]};
            end
        end
        amplitude = sum;
    end

endmodule

`default_nettype wire

// ----- src/psg_gen.sv -----
// ----------------------------------------------------------------------------
// psg_gen
// Register file, tone counters, noise shift register and envelope sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_gen (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire psg_pkg::psg_cmd_t cmd,
    output psg_pkg::psg_mix_view_t view,
    output logic [7:0]             read_data
);
    import psg_pkg::*;

    logic [NUM_REGS-1:0][7:0]   regs_reg, regs_next;
    logic [NUM_CHANS-1:0][11:0] tone_count_reg, tone_count_next;
    logic [NUM_CHANS-1:0]       tone_level_reg, tone_level_next;
    logic [5:0]                 noise_count_reg, noise_count_next;
    logic [16:0]                noise_shift_reg, noise_shift_next;
    logic                       noise_level_reg, noise_level_next;
    logic [20:0]                env_count_reg, env_count_next;
    logic [4:0]                 env_step_reg, env_step_next;
    logic                       env_attack_reg, env_attack_next;
    logic [3:0]                 env_volume_reg, env_volume_next;

    logic [NUM_CHANS-1:0][11:0] tone_period;
    logic [4:0]                 noise_period;
    logic [15:0]                env_period;

    // Derived periods always follow the register file, with zero read as one.
    always_comb
    begin
        logic [11:0] tp;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            tp = {regs_reg[2*c+1][3:0], regs_reg[2*c]};
            tone_period[c] = (tp == 12'd0) ? 12'd1 : tp;
        end
        noise_period = (regs_reg[REG_NOISE_PER][4:0] == 5'd0) ? 5'd1
                                                              : regs_reg[REG_NOISE_PER][4:0];
        env_period = ({regs_reg[REG_ENV_HI], regs_reg[REG_ENV_LO]} == 16'd0) ? 16'd1
                   : {regs_reg[REG_ENV_HI], regs_reg[REG_ENV_LO]};
    end

    always_comb
    begin
        logic [11:0] t_inc;
        logic [5:0]  n_inc;
        logic [20:0] e_inc;
        logic [7:0]  shape;
        regs_next        = regs_reg;
        tone_count_next  = tone_count_reg;
        tone_level_next  = tone_level_reg;
        noise_count_next = noise_count_reg;
        noise_shift_next = noise_shift_reg;
        noise_level_next = noise_level_reg;
        env_count_next   = env_count_reg;
        env_step_next    = env_step_reg;
        env_attack_next  = env_attack_reg;
        env_volume_next  = env_volume_reg;
        shape            = regs_reg[REG_ENV_SHAPE];
        if (step)
        begin
            case (psg_op_t'(cmd.op))
                OP_WRITE:
                begin
                    regs_next[cmd.idx] = cmd.data;
                    if (cmd.idx == REG_ENV_SHAPE)
                    begin
                        env_step_next   = 5'd0;
                        env_count_next  = 21'd0;
                        env_attack_next = cmd.data[2];
                        env_volume_next = cmd.data[2] ? 4'd0 : 4'd15;
                    end
                end
                OP_READ:
                begin
                end
                OP_TICK:
                begin
                    for (int c = 0; c < NUM_CHANS; c++)
                    begin
                        t_inc = tone_count_reg[c] + 12'd1;
                        if (t_inc >= tone_period[c])
                        begin
                            tone_count_next[c] = 12'd0;
                            tone_level_next[c] = ~tone_level_reg[c];
                        end
                        else
                        begin
                            tone_count_next[c] = t_inc;
                        end
                    end
                    n_inc = noise_count_reg + 6'd1;
                    if (n_inc >= {noise_period, 1'b0})
                    begin
                        noise_count_next = 6'd0;
                        noise_shift_next = {noise_shift_reg[0] ^ noise_shift_reg[3],
                                            noise_shift_reg[16:1]};
                        noise_level_next = noise_shift_reg[1];
                    end
                    else
                    begin
                        noise_count_next = n_inc;
                    end
                    e_inc = env_count_reg + 21'd1;
                    if (e_inc >= {env_period, 5'd0})
                    begin
                        env_count_next = 21'd0;
                        if (!env_step_reg[4])
                        begin
                            env_volume_next = env_attack_reg ? env_step_reg[3:0]
                                                             : 4'd15 - env_step_reg[3:0];
                            env_step_next = env_step_reg + 5'd1;
                        end
                        else if (!shape[3])
                        begin
                            env_volume_next = 4'd0;
                        end
                        else if (shape[0])
                        begin
                            env_volume_next = (env_attack_reg ^ shape[1]) ? 4'd15 : 4'd0;
                        end
                        else
                        begin
                            env_attack_next = env_attack_reg ^ shape[1];
                            env_step_next   = 5'd0;
                            env_volume_next = (env_attack_reg ^ shape[1]) ? 4'd0 : 4'd15;
                        end
                    end
                    else
                    begin
                        env_count_next = e_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg        <= '0;
            tone_count_reg  <= '0;
            tone_level_reg  <= '0;
            noise_count_reg <= '0;
            noise_shift_reg <= 17'd1;
            noise_level_reg <= 1'b0;
            env_count_reg   <= '0;
            env_step_reg    <= '0;
            env_attack_reg  <= 1'b0;
            env_volume_reg  <= '0;
        end
        else
        begin
            regs_reg        <= regs_next;
            tone_count_reg  <= tone_count_next;
            tone_level_reg  <= tone_level_next;
            noise_count_reg <= noise_count_next;
            noise_shift_reg <= noise_shift_next;
            noise_level_reg <= noise_level_next;
            env_count_reg   <= env_count_next;
            env_step_reg    <= env_step_next;
            env_attack_reg  <= env_attack_next;
            env_volume_reg  <= env_volume_next;
        end
    end

    always_comb
    begin
        view.mixer      = regs_next[REG_MIXER];
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            view.level[c] = regs_next[REG_LEVEL_A + 4'(c)];
        end
        view.tone       = tone_level_next;
        view.noise      = noise_level_next;
        view.env_volume = env_volume_next;
    end

    assign read_data = (psg_op_t'(cmd.op) == OP_READ) ? regs_reg[cmd.idx] : 8'd0;

endmodule

`default_nettype wire

// ----- tb/psg_square_noise_envelope_tb.sv -----
// ----------------------------------------------------------------------------
// psg_square_noise_envelope_tb
// Self-checking testbench for the three-channel sound generator. A driver
// offers command words from a queue, and a sink takes result words with random
// stalls. A predictor written here keeps its own copy of the registers, tone,
// noise and envelope counters, and checks every result word in order. After a
// short directed run, one long envelope ramp runs out to its end, and then a
// random mix of writes, reads and ticks follows.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_square_noise_envelope_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psg_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_TONE_A_HI = 4'd1;
    localparam logic [3:0] REG_TONE_B_LO = 4'd2;
    localparam logic [3:0] REG_TONE_B_HI = 4'd3;
    localparam logic [3:0] REG_TONE_C_HI = 4'd5;
    localparam logic [3:0] REG_LEVEL_B   = 4'd9;
    localparam logic [3:0] REG_LEVEL_C   = 4'd10;
    localparam logic [3:0] REG_PORT_B    = 4'd15;
    localparam int SHAPE_HOLD   = 0;
    localparam int SHAPE_ALT    = 1;
    localparam int SHAPE_ATTACK = 2;
    localparam int SHAPE_CONT   = 3;
    localparam int ITEM_TARGET  = 1050;
    localparam int RAMP_TICKS   = 560;

    typedef struct packed {
        logic [6:0] amplitude;
        logic [7:0] read_data;
    } sound_result_t;

    logic clk;
    logic rst_n;

    psg_cmd_if cmd_ch ();
    psg_res_if res_ch ();

    psg_square_noise_envelope DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Predictor state.
    logic [7:0]  gen_regs [NUM_REGS];
    logic [11:0] tone_cnt [NUM_CHANS];
    logic [11:0] tone_per [NUM_CHANS];
    logic        tone_lvl [NUM_CHANS];
    logic [5:0]  noise_cnt;
    logic [4:0]  noise_per;
    logic [16:0] noise_lfsr;
    logic        noise_lvl;
    logic [20:0] env_cnt;
    logic [15:0] env_per;
    logic [4:0]  env_step;
    logic        env_attack;
    logic [3:0]  env_vol;

    psg_cmd_t      cmd_words [$];
    sound_result_t awaited_results [$];

    int  fault_count;
    int  queued_total;
    int  words_sent;
    int  results_checked;
    int  n_writes;
    int  n_reads;
    int  n_ticks;
    int  cycle_cnt;
    int  tx_gap;
    int  rx_stall;
    bit  cmd_taken;
    bit  sink_hold;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic log_fault(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fault_count++;
    endtask

    function automatic void reset_predictor();
        for (int r = 0; r < NUM_REGS; r++)
        begin
            gen_regs[r] = 8'h00;
        end
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            tone_cnt[c] = '0;
            tone_per[c] = 12'd1;
            tone_lvl[c] = 1'b0;
        end
        noise_cnt  = '0;
        noise_per  = 5'd1;
        noise_lfsr = 17'd1;
        noise_lvl  = 1'b0;
        env_cnt    = '0;
        env_per    = 16'd1;
        env_step   = '0;
        env_attack = 1'b0;
        env_vol    = '0;
    endfunction

    function automatic void apply_write(input logic [3:0] idx, input logic [7:0] data);
        logic [11:0] tp;
        logic [15:0] ep;
        gen_regs[idx] = data;
        if (idx <= REG_TONE_C_HI)
        begin
            tp = {gen_regs[{idx[3:1], 1'b1}][3:0], gen_regs[{idx[3:1], 1'b0}]};
            tone_per[idx[2:1]] = (tp == 0) ? 12'd1 : tp;
        end
        else if (idx == REG_NOISE_PER)
        begin
            noise_per = (data[4:0] == 0) ? 5'd1 : data[4:0];
        end
        else if (idx == REG_ENV_LO || idx == REG_ENV_HI)
        begin
            ep = {gen_regs[REG_ENV_HI], gen_regs[REG_ENV_LO]};
            env_per = (ep == 0) ? 16'd1 : ep;
        end
        else if (idx == REG_ENV_SHAPE)
        begin
            env_step   = '0;
            env_cnt    = '0;
            env_attack = data[SHAPE_ATTACK];
            env_vol    = env_attack ? 4'd0 : 4'd15;
        end
    endfunction

    function automatic void advance_tick();
        logic [7:0] shape;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            tone_cnt[c] = tone_cnt[c] + 12'd1;
            if (tone_cnt[c] >= tone_per[c])
            begin
                tone_cnt[c] = '0;
                tone_lvl[c] = ~tone_lvl[c];
            end
        end
        noise_cnt = noise_cnt + 6'd1;
        if (noise_cnt >= {noise_per, 1'b0})
        begin
            noise_cnt  = '0;
            noise_lfsr = {noise_lfsr[0] ^ noise_lfsr[3], noise_lfsr[16:1]};
            noise_lvl  = noise_lfsr[0];
        end
        env_cnt = env_cnt + 21'd1;
        if (env_cnt >= {env_per, 5'd0})
        begin
            shape   = gen_regs[REG_ENV_SHAPE];
            env_cnt = '0;
            if (env_step < 5'd16)
            begin
                env_vol  = env_attack ? env_step[3:0] : 4'd15 - env_step[3:0];
                env_step = env_step + 5'd1;
            end
            else if (!shape[SHAPE_CONT])
            begin
                env_vol = 4'd0;
            end
            else if (shape[SHAPE_HOLD])
            begin
                env_vol = (env_attack ^ shape[SHAPE_ALT]) ? 4'd15 : 4'd0;
            end
            else
            begin
                if (shape[SHAPE_ALT])
                begin
                    env_attack = ~env_attack;
                end
                env_step = '0;
                env_vol  = env_attack ? 4'd0 : 4'd15;
            end
        end
    endfunction

    function automatic logic [6:0] mixed_amplitude();
        int         sum;
        logic [7:0] lreg;
        logic [3:0] lvl;
        sum = 0;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            lreg = gen_regs[REG_LEVEL_A + 4'(c)];
            if ((gen_regs[REG_MIXER][c] || tone_lvl[c]) &&
                (gen_regs[REG_MIXER][c + 3] || noise_lvl))
            begin
                lvl = lreg[4] ? env_vol : lreg[3:0];
                sum += int'(VOL_TABLE[lvl]);
            end
        end
        return sum[6:0];
    endfunction

    function automatic sound_result_t predict_word(input psg_cmd_t w);
        sound_result_t r;
        r.read_data = 8'h00;
        case (w.op)
            OP_WRITE: apply_write(w.idx, w.data);
            OP_READ:  r.read_data = gen_regs[w.idx];
            OP_TICK:  advance_tick();
            default:  ;
        endcase
        r.amplitude = mixed_amplitude();
        return r;
    endfunction

    function automatic int idle_gap(input bit quiet);
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 75)
            return 0;
        else if (p < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [3:0] plain_reg();
        logic [3:0] r;
        do
        begin
            r = 4'($urandom_range(0, 15));
        end
        while (r == REG_ENV_LO || r == REG_ENV_HI || r == REG_ENV_SHAPE);
        return r;
    endfunction

    // Most writes keep periods short so that tones, noise and envelope move.
    function automatic logic [7:0] reg_payload(input logic [3:0] idx);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 7)
        begin
            if (idx <= REG_TONE_C_HI && idx[0])
                v[3:0] = 4'h0;
            else if (idx <= REG_TONE_C_HI)
                v = 8'($urandom_range(0, 12));
            else if (idx == REG_NOISE_PER)
                v[4:0] = 5'($urandom_range(0, 3));
            else if (idx == REG_ENV_LO)
                v = 8'($urandom_range(0, 2));
            else if (idx == REG_ENV_HI)
                v = 8'h00;
        end
        return v;
    endfunction

    task automatic add_word(input logic [1:0] op, input logic [3:0] idx,
                            input logic [7:0] data);
        psg_cmd_t w;
        w.op   = op;
        w.idx  = idx;
        w.data = data;
        cmd_words.push_back(w);
        queued_total++;
    endtask

    task automatic wait_drained();
        while (cmd_words.size() != 0 || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Command driver: holds an offered word until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && !(cmd_ch.valid && !cmd_taken))
        begin
            if (tx_gap != 0)
            begin
                tx_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_words.size() != 0)
            begin
                cmd_ch.valid      <= 1'b1;
                cmd_ch.opcode     <= cmd_words[0].op;
                cmd_ch.reg_index  <= cmd_words[0].idx;
                cmd_ch.write_data <= cmd_words[0].data;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink with random stalls.
    always @(negedge clk)
    begin
        cycle_cnt++;
        if (rx_stall != 0)
            rx_stall--;
        else
            rx_stall = idle_gap((cycle_cnt % 512) < 100);
        res_ch.ready <= (rx_stall == 0) && !sink_hold;
    end

    // Monitor: predicts on each accepted command word and checks each result word.
    always @(posedge clk)
    begin
        sound_result_t want;
        psg_cmd_t      w;
        cmd_taken = 1'b0;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_taken = 1'b1;
                w.op   = cmd_ch.opcode;
                w.idx  = cmd_ch.reg_index;
                w.data = cmd_ch.write_data;
                awaited_results.push_back(predict_word(w));
                case (w.op)
                    OP_WRITE: n_writes++;
                    OP_READ:  n_reads++;
                    OP_TICK:  n_ticks++;
                    default:  ;
                endcase
                void'(cmd_words.pop_front());
                words_sent++;
                tx_gap = idle_gap((words_sent % 200) < 40);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    log_fault($sformatf("result word with none expected (amp %0d, data %0h)",
                                        res_ch.amplitude, res_ch.read_data));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (res_ch.amplitude !== want.amplitude)
                        log_fault($sformatf("result %0d: amplitude %0d, expected %0d",
                                            results_checked, res_ch.amplitude,
                                            want.amplitude));
                    if (res_ch.read_data !== want.read_data)
                        log_fault($sformatf("result %0d: read_data %0h, expected %0h",
                                            results_checked, res_ch.read_data,
                                            want.read_data));
                end
                results_checked++;
            end
        end
    end

    // The sink holds off for a long stretch while the sender keeps offering words.
    initial
    begin
        sink_hold = 1'b0;
        wait (results_checked >= 150);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (120) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int         pick;
        int         ramp_ticks;
        logic [3:0] idx;
        fault_count       = 0;
        queued_total      = 0;
        words_sent        = 0;
        results_checked   = 0;
        n_writes          = 0;
        n_reads           = 0;
        n_ticks           = 0;
        cycle_cnt         = 0;
        tx_gap            = 0;
        rx_stall          = 0;
        cmd_taken         = 1'b0;
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_WRITE;
        cmd_ch.reg_index  = 4'h0;
        cmd_ch.write_data = 8'h00;
        res_ch.ready      = 1'b0;
        reset_predictor();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_word(OP_READ,   REG_MIXER,     8'h00);
        add_word(OP_TICK,   REG_MIXER,     8'h00);
        add_word(OP_WRITE,  REG_MIXER,     8'hFF);
        add_word(OP_WRITE,  REG_LEVEL_A,   8'h0F);
        add_word(OP_WRITE,  REG_LEVEL_B,   8'h00);
        add_word(OP_WRITE,  REG_LEVEL_C,   8'h1F);
        add_word(OP_WRITE,  REG_ENV_SHAPE, 8'h00);
        add_word(OP_WRITE,  REG_TONE_A_LO, 8'h00);
        add_word(OP_WRITE,  REG_TONE_A_HI, 8'h00);
        add_word(OP_WRITE,  REG_TONE_B_LO, 8'hFF);
        add_word(OP_WRITE,  REG_TONE_B_HI, 8'hFF);
        add_word(OP_READ,   REG_TONE_B_HI, 8'hFF);
        add_word(OP_WRITE,  REG_NOISE_PER, 8'hE0);
        add_word(OP_READ,   REG_NOISE_PER, 8'h00);
        add_word(OP_WRITE,  REG_ENV_LO,    8'h00);
        add_word(OP_WRITE,  REG_ENV_HI,    8'h00);
        add_word(OP_WRITE,  REG_PORT_B,    8'h5A);
        add_word(OP_READ,   REG_PORT_B,    8'hA5);
        add_word(OP_WRITE,  REG_MIXER,     8'h00);
        add_word(OP_TICK,   REG_PORT_B,    8'hFF);
        add_word(OP_TICK,   REG_TONE_A_LO, 8'h00);
        add_word(OP_TICK,   REG_PORT_B,    8'hFF);
        add_word(OP_UNUSED, REG_MIXER,     8'hFF);
        add_word(OP_WRITE,  REG_ENV_SHAPE, 8'h0F);
        add_word(OP_TICK,   REG_TONE_A_LO, 8'h00);
        wait_drained();

        // One envelope ramp with a short period, run past its end.
        add_word(OP_WRITE, REG_ENV_LO, 8'($urandom_range(0, 1)));
        add_word(OP_WRITE, REG_ENV_HI, 8'h00);
        add_word(OP_WRITE, REG_ENV_SHAPE, 8'($urandom_range(0, 255)));
        ramp_ticks = 0;
        while (ramp_ticks < RAMP_TICKS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                add_word(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                ramp_ticks++;
            end
            else if (pick < 96)
            begin
                idx = plain_reg();
                add_word(OP_WRITE, idx, reg_payload(idx));
            end
            else
            begin
                add_word(OP_READ, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
        end
        wait_drained();

        while (queued_total < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            idx  = 4'($urandom_range(0, 15));
            if (pick < 60)
                add_word(OP_TICK, idx, 8'($urandom_range(0, 255)));
            else if (pick < 90)
                add_word(OP_WRITE, idx, reg_payload(idx));
            else
                add_word(OP_READ, idx, 8'($urandom_range(0, 255)));
        end
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d result words from %0d command words: %0d writes, %0d reads,",
                 results_checked, words_sent, n_writes, n_reads);
        $display("%0d ticks including one full envelope ramp; %0d mismatches.",
                 n_ticks, fault_count);
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
